// ===== rtl/tesp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tesp_pkg
// Shared types and byte codes of the terminal escape sequence parser.
// ---------------------------------------------------------------------------
package tesp_pkg;

    // default width of the decimal parameter accumulator
    localparam int NUMBER_WIDTH_DEF = 16;

    // width of the reported number field
    localparam int NUM_OUT_W = 16;

    // byte codes
    localparam logic [7:0] CH_BEL       = 8'h07;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DIGIT_0   = 8'h30;
    localparam logic [7:0] CH_DIGIT_9   = 8'h39;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_FINAL_MIN = 8'h40;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_TILDE     = 8'h7E;

    // result action codes
    typedef enum logic [2:0] {
        ACT_PRINT     = 3'd0,
        ACT_BACKSPACE = 3'd1,
        ACT_BELL      = 3'd2,
        ACT_CSI       = 3'd3,
        ACT_OSC_TEXT  = 3'd4,
        ACT_OSC_END   = 3'd5,
        ACT_ABANDON   = 3'd6
    } t_action;

    // one result item plus its emit flag
    typedef struct packed {
        logic                 emit;
        t_action              action;
        logic [7:0]           byte_value;
        logic [NUM_OUT_W-1:0] number;
    } t_result;

endpackage

// ===== rtl/terminal_escape_sequence_parser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// terminal_escape_sequence_parser
// Byte classifier for terminal output with CSI and OSC escape sequences.
// ---------------------------------------------------------------------------
// One byte item enters per clock; each byte gives zero or one result item.
// A byte goes through an input register, the parser core and a result
// register; its result becomes valid once the core has loaded it into
// the result register. The block sustains one byte per cycle as long as
// the consumer keeps i_ready high. Stalls on the output back up through
// the result register into the input register. The decimal parameter is
// accumulated in a NUMBER_WIDTH bit register that saturates at all ones;
// o_number shows its low 16 bits.
module terminal_escape_sequence_parser #(
    parameter int NUMBER_WIDTH = tesp_pkg::NUMBER_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_action,
    output logic [7:0]  o_byte_value,
    output logic [15:0] o_number
);
    import tesp_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_can_load;
    logic       take;
    t_result    core_res;

    // a byte moves into the core when the result register has room
    assign take = in_valid && out_can_load;

    // input register
    tesp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_byte_in (i_byte_in),
        .i_take    (take),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    // parser core
    tesp_core #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (in_byte),
        .o_res   (core_res)
    );

    // result register
    tesp_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (take),
        .i_res        (core_res),
        .i_ready      (i_ready),
        .o_can_load   (out_can_load),
        .o_valid      (o_valid),
        .o_action     (o_action),
        .o_byte_value (o_byte_value),
        .o_number     (o_number)
    );

endmodule

// ===== rtl/tesp_in_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tesp_in_stage
// Input register: holds one byte item until the parser core takes it.
// ---------------------------------------------------------------------------
module tesp_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte_in,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // free when empty or when the held item leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    // item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
        if (i_valid && o_ready) begin
            r_byte <= i_byte_in;
        end
    end

    // a held item is not overwritten while it waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_take |=> r_valid && $stable(r_byte))
        else $error("held input item lost");

endmodule

// ===== rtl/tesp_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tesp_core
// Parser state and per-byte classification; one byte per take.
// ---------------------------------------------------------------------------
module tesp_core #(
    parameter int NUMBER_WIDTH = tesp_pkg::NUMBER_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    output tesp_pkg::t_result o_res
);
    import tesp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ESC,
        S_CSI,
        S_OSC,
        S_OSC_ESC
    } t_mode;

    t_mode                   r_mode, n_mode;
    logic [NUMBER_WIDTH-1:0] r_acc, n_acc;
    logic                    r_digits_only, n_digits_only;
    logic                    r_sep, n_sep;

    logic                    is_digit;
    logic [NUMBER_WIDTH+3:0] acc_wide;
    logic [NUMBER_WIDTH-1:0] acc_step;
    logic [NUMBER_WIDTH-1:0] param;
    logic [NUMBER_WIDTH+NUM_OUT_W-1:0] param_ext;
    logic [NUM_OUT_W-1:0]    param_out;
    t_result                 res;

    // acc * 10 + digit, saturated
    assign is_digit = (i_byte >= CH_DIGIT_0) && (i_byte <= CH_DIGIT_9);
    assign acc_wide = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                    + {{NUMBER_WIDTH{1'b0}}, i_byte[3:0]};
    assign acc_step = (|acc_wide[NUMBER_WIDTH+3:NUMBER_WIDTH])
                    ? {NUMBER_WIDTH{1'b1}} : acc_wide[NUMBER_WIDTH-1:0];

    // parameter value, low bits of the reported field
    assign param     = r_digits_only ? r_acc : '0;
    assign param_ext = {{NUM_OUT_W{1'b0}}, param};
    assign param_out = param_ext[NUM_OUT_W-1:0];

    // next state and result
    always_comb begin
        n_mode         = r_mode;
        n_acc          = r_acc;
        n_digits_only  = r_digits_only;
        n_sep          = r_sep;
        res.emit       = 1'b0;
        res.action     = ACT_PRINT;
        res.byte_value = i_byte;
        res.number     = '0;
        unique case (r_mode)
            S_ESC: begin
                n_acc         = '0;
                n_digits_only = 1'b1;
                n_sep         = 1'b0;
                if (i_byte == CH_LBRACKET) begin
                    n_mode = S_CSI;
                end else if (i_byte == CH_RBRACKET) begin
                    n_mode = S_OSC;
                end else begin
                    n_mode     = S_IDLE;
                    res.emit   = 1'b1;
                    res.action = ACT_ABANDON;
                end
            end
            S_CSI: begin
                if (i_byte < CH_SPACE || i_byte > CH_TILDE) begin
                    n_mode        = S_IDLE;
                    n_acc         = '0;
                    n_digits_only = 1'b1;
                    n_sep         = 1'b0;
                    res.emit      = 1'b1;
                    res.action    = ACT_ABANDON;
                end else if (i_byte >= CH_FINAL_MIN) begin
                    n_mode        = S_IDLE;
                    n_acc         = '0;
                    n_digits_only = 1'b1;
                    n_sep         = 1'b0;
                    res.emit      = 1'b1;
                    res.action    = ACT_CSI;
                    res.number    = param_out;
                end else if (is_digit) begin
                    n_acc = acc_step;
                end else begin
                    n_digits_only = 1'b0;
                end
            end
            S_OSC: begin
                if (i_byte == CH_BEL) begin
                    n_mode        = S_IDLE;
                    n_acc         = '0;
                    n_digits_only = 1'b1;
                    n_sep         = 1'b0;
                    res.emit      = 1'b1;
                    res.action    = ACT_OSC_END;
                    res.number    = r_sep ? param_out : '0;
                end else if (i_byte == CH_ESC) begin
                    n_mode = S_OSC_ESC;
                end else if (r_sep) begin
                    res.emit   = 1'b1;
                    res.action = ACT_OSC_TEXT;
                end else if (i_byte == CH_SEMICOLON) begin
                    n_sep = 1'b1;
                end else if (is_digit) begin
                    n_acc = acc_step;
                end else begin
                    n_digits_only = 1'b0;
                end
            end
            S_OSC_ESC: begin
                n_mode        = S_IDLE;
                n_acc         = '0;
                n_digits_only = 1'b1;
                n_sep         = 1'b0;
                res.emit      = 1'b1;
                if (i_byte == CH_BACKSLASH) begin
                    res.action = ACT_OSC_END;
                    res.number = r_sep ? param_out : '0;
                end else begin
                    res.action = ACT_ABANDON;
                end
            end
            S_IDLE: begin
                priority if (i_byte == CH_ESC) begin
                    n_mode = S_ESC;
                end else if (i_byte == CH_CR) begin
                    n_mode = S_IDLE;
                end else if (i_byte == CH_BS) begin
                    res.emit   = 1'b1;
                    res.action = ACT_BACKSPACE;
                end else if (i_byte == CH_BEL) begin
                    res.emit   = 1'b1;
                    res.action = ACT_BELL;
                end else begin
                    res.emit   = 1'b1;
                    res.action = ACT_PRINT;
                end
            end
            default: begin
                n_mode = S_IDLE;
            end
        endcase
    end

    assign o_res = res;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= S_IDLE;
            r_acc         <= '0;
            r_digits_only <= 1'b1;
            r_sep         <= 1'b0;
        end else if (i_take) begin
            r_mode        <= n_mode;
            r_acc         <= n_acc;
            r_digits_only <= n_digits_only;
            r_sep         <= n_sep;
        end
    end

    // a byte after ESC always starts with a clean parameter
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && r_mode == S_ESC |=> r_acc == '0 && r_digits_only && !r_sep)
        else $error("parameter not cleared after escape");

    // the byte after an escape inside an os command always gives a result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == S_OSC_ESC |-> res.emit)
        else $error("os command escape without result");

    // the separator only exists inside an os command
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sep |-> r_mode == S_OSC || r_mode == S_OSC_ESC)
        else $error("separator flag outside os command");

endmodule

// ===== rtl/tesp_out_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tesp_out_stage
// Result register: holds one result item until the consumer takes it.
// ---------------------------------------------------------------------------
module tesp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tesp_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_can_load,
    output logic              o_valid,
    output logic [2:0]        o_action,
    output logic [7:0]        o_byte_value,
    output logic [15:0]       o_number
);
    import tesp_pkg::*;

    logic                 r_valid;
    t_action              r_action;
    logic [7:0]           r_byte_value;
    logic [NUM_OUT_W-1:0] r_number;

    // room when empty or when the held result leaves this cycle
    assign o_can_load   = !r_valid || i_ready;
    assign o_valid      = r_valid;
    assign o_action     = r_action;
    assign o_byte_value = r_byte_value;
    assign o_number     = r_number;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res.emit;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_load && i_res.emit) begin
            r_action     <= i_res.action;
            r_byte_value <= i_res.byte_value;
            r_number     <= i_res.number;
        end
    end

    // a number is reported only with a control sequence or os command end
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_action != ACT_CSI && r_action != ACT_OSC_END |-> r_number == '0)
        else $error("number on an action that carries none");

endmodule
